@@ rtl/psfc_pkg.sv @@
// ============================================================================
// psfc_pkg
// Shared codes, types and helper functions of the PCM sample format converter.
// ============================================================================
package psfc_pkg;

	// Format codes as held in the source and destination registers.
	localparam int FMT_W = 3;
	typedef logic [FMT_W-1:0] fmt_t;
	localparam fmt_t FMT_U8   = 3'd0;
	localparam fmt_t FMT_S16  = 3'd1;
	localparam fmt_t FMT_S32  = 3'd2;
	localparam fmt_t FMT_FL32 = 3'd3;
	localparam fmt_t FMT_FL64 = 3'd4;

	// Configuration port.
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = FMT_W;
	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
	localparam cfg_idx_t REG_SRC_FMT = 1'b0;
	localparam cfg_idx_t REG_DST_FMT = 1'b1;

	// Sample word width.
	localparam int SMP_W = 64;

	// Signed exponent of the internal value form.
	localparam int EXP_W = 13;
	typedef logic signed [EXP_W-1:0] exp_t;

	// Unpacked item: either a finished result (bypass) or a finite nonzero
	// magnitude with the exponent of its bit zero.
	typedef struct packed {
		logic             bypass;
		logic [SMP_W-1:0] byp_val;
		logic             sign;
		logic [SMP_W-1:0] mag;
		exp_t             expo;
		fmt_t             dst;
		logic             rne;
	} unp_t;

	// Number of integer bits below the sign of an integer format.
	function automatic exp_t int_bits(fmt_t f);
		exp_t n;
		begin
			if (f == FMT_U8) begin
				n = 13'sd7;
			end else if (f == FMT_S16) begin
				n = 13'sd15;
			end else begin
				n = 13'sd31;
			end
			return n;
		end
	endfunction

	// Saturated integer result for the given sign.
	function automatic logic [SMP_W-1:0] sat_val(fmt_t f, logic neg);
		logic [SMP_W-1:0] r;
		begin
			if (f == FMT_U8) begin
				r = neg ? 64'h0 : 64'hFF;
			end else if (f == FMT_S16) begin
				r = neg ? 64'h8000 : 64'h7FFF;
			end else begin
				r = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
			end
			return r;
		end
	endfunction

	// Midscale integer result, used for zero and NaN.
	function automatic logic [SMP_W-1:0] int_mid(fmt_t f);
		return (f == FMT_U8) ? 64'h80 : 64'h0;
	endfunction

endpackage

@@ rtl/psfc_ifs.sv @@
// ============================================================================
// psfc_ifs
// Valid/ready stream interfaces for sample items and result items.
// ============================================================================
interface psfc_sample_if;
	logic        valid;
	logic        ready;
	logic [63:0] sample_bits;
	modport source(output valid, output sample_bits, input ready);
	modport sink(input valid, input sample_bits, output ready);
endinterface

interface psfc_result_if;
	logic        valid;
	logic        ready;
	logic [63:0] converted_bits;
	modport source(output valid, output converted_bits, input ready);
	modport sink(input valid, input converted_bits, output ready);
endinterface

@@ rtl/psfc_unpack.sv @@
// ============================================================================
// psfc_unpack
// Decodes one sample into magnitude and exponent, or into a finished result
// for passthrough, integer-to-integer and special values.
// ============================================================================
module psfc_unpack (
	input  psfc_pkg::fmt_t            src_fmt,
	input  psfc_pkg::fmt_t            dst_fmt,
	input  logic [63:0]               sample,
	output psfc_pkg::unp_t            unp
);

	logic [63:0]     b;
	logic [31:0]     w;
	logic [31:0]     mag32;
	logic            fmt_ok;
	logic            sfl;
	logic            dfl;
	logic            sgn;
	logic            is_nan;
	logic            is_inf;
	logic            is_zero;
	logic [63:0]     fm;
	psfc_pkg::exp_t  fx;
	logic [63:0]     ii_val;
	logic [63:0]     nan_val;
	logic [63:0]     inf_val;
	logic [63:0]     zero_val;

	// Field decode of every source encoding.
	always_comb begin
		fmt_ok = (src_fmt <= psfc_pkg::FMT_FL64) && (dst_fmt <= psfc_pkg::FMT_FL64);
		sfl = (src_fmt >= psfc_pkg::FMT_FL32);
		dfl = (dst_fmt >= psfc_pkg::FMT_FL32);

		if (src_fmt == psfc_pkg::FMT_U8) begin
			b = {56'h0, sample[7:0]};
		end else if (src_fmt == psfc_pkg::FMT_S16) begin
			b = {48'h0, sample[15:0]};
		end else if (src_fmt == psfc_pkg::FMT_FL64) begin
			b = sample;
		end else begin
			b = {32'h0, sample[31:0]};
		end

		// Integer sample left-aligned as a 32-bit two's complement word.
		if (src_fmt == psfc_pkg::FMT_U8) begin
			w = {b[7:0] ^ 8'h80, 24'h0};
		end else if (src_fmt == psfc_pkg::FMT_S16) begin
			w = {b[15:0], 16'h0};
		end else begin
			w = b[31:0];
		end
		mag32 = w[31] ? (~w + 32'd1) : w;

		if (dst_fmt == psfc_pkg::FMT_U8) begin
			ii_val = {56'h0, w[31:24] ^ 8'h80};
		end else if (dst_fmt == psfc_pkg::FMT_S16) begin
			ii_val = {48'h0, w[31:16]};
		end else begin
			ii_val = {32'h0, w};
		end

		// Float fields, classes and value of bit zero.
		if (src_fmt == psfc_pkg::FMT_FL64) begin
			sgn     = b[63];
			is_nan  = (b[62:52] == 11'h7FF) && (b[51:0] != 52'h0);
			is_inf  = (b[62:52] == 11'h7FF) && (b[51:0] == 52'h0);
			is_zero = (b[62:52] == 11'h0) && (b[51:0] == 52'h0);
			if (b[62:52] == 11'h0) begin
				fm = {12'h0, b[51:0]};
				fx = -13'sd1074;
			end else begin
				fm = {11'h0, 1'b1, b[51:0]};
				fx = $signed({2'b00, b[62:52]}) - 13'sd1075;
			end
			nan_val = {32'h0, b[63], 8'hFF, 1'b1, b[50:29]};
		end else begin
			sgn     = b[31];
			is_nan  = (b[30:23] == 8'hFF) && (b[22:0] != 23'h0);
			is_inf  = (b[30:23] == 8'hFF) && (b[22:0] == 23'h0);
			is_zero = (b[30:23] == 8'h0) && (b[22:0] == 23'h0);
			if (b[30:23] == 8'h0) begin
				fm = {41'h0, b[22:0]};
				fx = -13'sd149;
			end else begin
				fm = {40'h0, 1'b1, b[22:0]};
				fx = $signed({5'b00000, b[30:23]}) - 13'sd150;
			end
			nan_val = {b[31], 11'h7FF, 1'b1, b[21:0], 29'h0};
		end

		if (dst_fmt == psfc_pkg::FMT_FL64) begin
			inf_val  = {sgn, 11'h7FF, 52'h0};
			zero_val = {sgn, 63'h0};
		end else begin
			inf_val  = {32'h0, sgn, 8'hFF, 23'h0};
			zero_val = {32'h0, sgn, 31'h0};
		end

		// Path selection.
		unp         = '0;
		unp.dst     = dst_fmt;
		unp.rne     = (src_fmt == psfc_pkg::FMT_FL32) && (dst_fmt == psfc_pkg::FMT_S16);
		unp.bypass  = 1'b1;
		if (!fmt_ok) begin
			unp.byp_val = 64'h0;
		end else if (src_fmt == dst_fmt) begin
			unp.byp_val = b;
		end else if (!sfl && !dfl) begin
			unp.byp_val = ii_val;
		end else if (!sfl) begin
			if (w == 32'h0) begin
				unp.byp_val = 64'h0;
			end else begin
				unp.bypass = 1'b0;
				unp.sign   = w[31];
				unp.mag    = {32'h0, mag32};
				unp.expo   = -13'sd31;
			end
		end else if (is_nan) begin
			unp.byp_val = dfl ? nan_val : psfc_pkg::int_mid(dst_fmt);
		end else if (is_inf) begin
			unp.byp_val = dfl ? inf_val : psfc_pkg::sat_val(dst_fmt, sgn);
		end else if (is_zero) begin
			unp.byp_val = dfl ? zero_val : psfc_pkg::int_mid(dst_fmt);
		end else begin
			unp.bypass = 1'b0;
			unp.sign   = sgn;
			unp.mag    = fm;
			unp.expo   = dfl ? fx : (fx + psfc_pkg::int_bits(dst_fmt));
		end
	end

endmodule

@@ rtl/pcm_sample_format_converter.sv @@
// ============================================================================
// pcm_sample_format_converter
// Converts audio samples between U8, S16, S32, IEEE single and IEEE double.
// ============================================================================
//
//  Channel   Kind        Payload
//  --------  ----------  ---------------------------------------
//  samples   sink        sample_bits    (64 bits, right-aligned)
//  results   source      converted_bits (64 bits, right-aligned)
//  cfg_*     write port  cfg_index selects source or dest format
//
// Six register stages: unpack, two normalize halves, shift amount, alignment
// shift, round and pack. One item is taken per cycle while the results side is not stalled.
// Reset clears the valid bits and loads source S16, destination FL32.
// Each stage holds while the next one is full and stalled; bubbles close up.
//
module pcm_sample_format_converter (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wr_en,
	input  psfc_pkg::cfg_idx_t                  cfg_index,
	input  logic [psfc_pkg::CFG_DATA_W-1:0]     cfg_data,
	psfc_sample_if.sink                         samples,
	psfc_result_if.source                       results
);

	psfc_pkg::fmt_t  src_fmt_q;
	psfc_pkg::fmt_t  dst_fmt_q;
	psfc_pkg::unp_t  unp;

	logic            v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic            rdy_s1, rdy_s2, rdy_s3, rdy_s4, rdy_s5, rdy_s6;

	psfc_pkg::unp_t  unp_s1, unp_s2, unp_s3, unp_s4;
	logic [5:0]      lz_s2;
	logic [6:0]      amt_s4;
	logic            ovf_s4;
	logic [7:0]      eb_s4;
	logic [10:0]     e64_s4;

	logic            byp_s5, sign_s5, rne_s5, ovf_s5, guard_s5, sticky_s5;
	logic [63:0]     bval_s5, keep_s5;
	psfc_pkg::fmt_t  dst_s5;
	logic [7:0]      eb_s5;
	logic [10:0]     e64_s5;
	logic [63:0]     res_s6;

	logic [63:0]     n2_mag;
	logic [5:0]      n2_lz;
	psfc_pkg::unp_t  n2_unp;
	logic [63:0]     n3_mag;
	logic [5:0]      n3_lz;
	psfc_pkg::unp_t  n3_unp;
	psfc_pkg::exp_t  ebf;
	psfc_pkg::exp_t  amt;
	logic            ovf4;
	logic [127:0]    sh;
	logic            inc;
	logic [30:0]     f31;
	logic [32:0]     mag33;
	logic [32:0]     r33;
	psfc_pkg::exp_t  ibits;
	logic [32:0]     lim;
	logic [63:0]     res;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_fmt_q <= psfc_pkg::FMT_S16;
			dst_fmt_q <= psfc_pkg::FMT_FL32;
		end else if (cfg_wr_en) begin
			if (cfg_index == psfc_pkg::REG_SRC_FMT) begin
				src_fmt_q <= cfg_data;
			end else begin
				dst_fmt_q <= cfg_data;
			end
		end
	end

	// Stage readiness: a stage loads when it is empty or its item moves on.
	assign rdy_s6 = !v_s6 || results.ready;
	assign rdy_s5 = !v_s5 || rdy_s6;
	assign rdy_s4 = !v_s4 || rdy_s5;
	assign rdy_s3 = !v_s3 || rdy_s4;
	assign rdy_s2 = !v_s2 || rdy_s3;
	assign rdy_s1 = !v_s1 || rdy_s2;
	assign samples.ready = rdy_s1;
	assign results.valid = v_s6;
	assign results.converted_bits = res_s6;

	// Valid bits travel with the items.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (rdy_s1) v_s1 <= samples.valid;
			if (rdy_s2) v_s2 <= v_s1;
			if (rdy_s3) v_s3 <= v_s2;
			if (rdy_s4) v_s4 <= v_s3;
			if (rdy_s5) v_s5 <= v_s4;
			if (rdy_s6) v_s6 <= v_s5;
		end
	end

	// Stage 1: decode the sample.
	psfc_unpack u_unpack (
		.src_fmt (src_fmt_q),
		.dst_fmt (dst_fmt_q),
		.sample  (samples.sample_bits),
		.unp     (unp)
	);

	// Stages 2 and 3: leading-zero normalize, coarse steps then fine steps.
	always_comb begin
		n2_mag = unp_s1.mag;
		n2_lz  = 6'd0;
		if (n2_mag[63:32] == 32'h0) begin
			n2_mag = n2_mag << 32;
			n2_lz  = n2_lz + 6'd32;
		end
		if (n2_mag[63:48] == 16'h0) begin
			n2_mag = n2_mag << 16;
			n2_lz  = n2_lz + 6'd16;
		end
		if (n2_mag[63:56] == 8'h0) begin
			n2_mag = n2_mag << 8;
			n2_lz  = n2_lz + 6'd8;
		end
		n2_unp     = unp_s1;
		n2_unp.mag = n2_mag;
		n3_mag = unp_s2.mag;
		n3_lz  = lz_s2;
		if (n3_mag[63:60] == 4'h0) begin
			n3_mag = n3_mag << 4;
			n3_lz  = n3_lz + 6'd4;
		end
		if (n3_mag[63:62] == 2'h0) begin
			n3_mag = n3_mag << 2;
			n3_lz  = n3_lz + 6'd2;
		end
		if (!n3_mag[63]) begin
			n3_mag = n3_mag << 1;
			n3_lz  = n3_lz + 6'd1;
		end
		n3_unp      = unp_s2;
		n3_unp.mag  = n3_mag;
		n3_unp.expo = unp_s2.expo + 13'sd63 - $signed({7'b0, n3_lz});
	end

	// Stage 4: right-shift amount and overflow per destination.
	always_comb begin
		ebf  = unp_s3.expo + 13'sd127;
		ovf4 = 1'b0;
		if (unp_s3.dst == psfc_pkg::FMT_FL32) begin
			ovf4 = (ebf >= 13'sd255);
			amt  = (ebf >= 13'sd1) ? 13'sd40 : (13'sd41 - ebf);
		end else if (unp_s3.dst == psfc_pkg::FMT_FL64) begin
			amt  = 13'sd11;
		end else begin
			ovf4 = (unp_s3.expo >= psfc_pkg::int_bits(unp_s3.dst));
			amt  = 13'sd63 - unp_s3.expo;
		end
	end

	// Stage 5: align with guard and sticky bits.
	assign sh = {unp_s4.mag, 64'h0} >> amt_s4;

	// Stage 6: round and pack.
	always_comb begin
		inc = (dst_s5 == psfc_pkg::FMT_FL32 || rne_s5) ?
			(guard_s5 & (sticky_s5 | keep_s5[0])) : guard_s5;
		f31   = {keep_s5[23] ? eb_s5 : 8'h0, keep_s5[22:0]} + {30'h0, inc};
		mag33 = keep_s5[32:0] + {32'h0, inc};
		ibits = psfc_pkg::int_bits(dst_s5);
		lim   = 33'd1 << ibits[4:0];
		r33   = sign_s5 ? (~mag33 + 33'd1) : mag33;
		if (byp_s5) begin
			res = bval_s5;
		end else if (dst_s5 == psfc_pkg::FMT_FL32) begin
			res = ovf_s5 ? {32'h0, sign_s5, 8'hFF, 23'h0} : {32'h0, sign_s5, f31};
		end else if (dst_s5 == psfc_pkg::FMT_FL64) begin
			res = {sign_s5, e64_s5, keep_s5[51:0]};
		end else if (ovf_s5 || (!sign_s5 && mag33 >= lim)) begin
			res = psfc_pkg::sat_val(dst_s5, sign_s5);
		end else if (dst_s5 == psfc_pkg::FMT_U8) begin
			res = {56'h0, r33[7:0] ^ 8'h80};
		end else if (dst_s5 == psfc_pkg::FMT_S16) begin
			res = {48'h0, r33[15:0]};
		end else begin
			res = {32'h0, r33[31:0]};
		end
	end

	// Pipeline payload registers.
	always_ff @(posedge clk) begin
		if (rdy_s1 && samples.valid) begin
			unp_s1 <= unp;
		end
		if (rdy_s2 && v_s1) begin
			unp_s2 <= n2_unp;
			lz_s2  <= n2_lz;
		end
		if (rdy_s3 && v_s2) begin
			unp_s3 <= n3_unp;
		end
		if (rdy_s4 && v_s3) begin
			unp_s4 <= unp_s3;
			ovf_s4 <= ovf4;
			eb_s4  <= ebf[7:0];
			e64_s4 <= 11'(unp_s3.expo + 13'sd1023);
			if (amt > 13'sd127) begin
				amt_s4 <= 7'd127;
			end else if (amt < 13'sd0) begin
				amt_s4 <= 7'd0;
			end else begin
				amt_s4 <= amt[6:0];
			end
		end
		if (rdy_s5 && v_s4) begin
			byp_s5    <= unp_s4.bypass;
			bval_s5   <= unp_s4.byp_val;
			sign_s5   <= unp_s4.sign;
			rne_s5    <= unp_s4.rne;
			dst_s5    <= unp_s4.dst;
			ovf_s5    <= ovf_s4;
			eb_s5     <= eb_s4;
			e64_s5    <= e64_s4;
			keep_s5   <= sh[127:64];
			guard_s5  <= sh[63];
			sticky_s5 <= |sh[62:0];
		end
		if (rdy_s6 && v_s5) begin
			res_s6 <= res;
		end
	end

`ifndef SYNTH
	// A converted magnitude is normalized after stage 3.
	a_norm: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 && !unp_s3.bypass |-> unp_s3.mag[63])
		else $error("magnitude not normalized");

	// Every non-special item in range shifts at least past the double fraction.
	a_amt: assert property (@(posedge clk) disable iff (!arst_n)
		v_s4 && !unp_s4.bypass && !ovf_s4 |-> amt_s4 >= 7'd11)
		else $error("alignment shift too small");

	// An empty first stage always takes an item.
	a_idle_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!v_s1 |-> samples.ready)
		else $error("empty pipeline refuses items");

	// A held stage-two item is not dropped while stage three is blocked.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 && !rdy_s3 |=> v_s2)
		else $error("stalled item lost");
`endif

endmodule
